// ----- design/ipdd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ipdd_pkg;

    localparam int TICK_W  = 20;
    localparam int INDEX_W = 6;
    localparam int CMD_W   = 8;
    localparam int REG_W   = 3;

    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

    localparam logic [REG_W-1:0] REG_TIMEOUT    = 3'd0;
    localparam logic [REG_W-1:0] REG_LEADER_MIN = 3'd1;
    localparam logic [REG_W-1:0] REG_LEADER_MAX = 3'd2;
    localparam logic [REG_W-1:0] REG_ONE_MIN    = 3'd3;
    localparam logic [REG_W-1:0] REG_ONE_MAX    = 3'd4;
    localparam logic [REG_W-1:0] REG_FIRST_BIT  = 3'd5;

    typedef struct packed {
        logic [TICK_W-1:0]  timeout_ticks;
        logic [TICK_W-1:0]  leader_min;
        logic [TICK_W-1:0]  leader_max;
        logic [TICK_W-1:0]  one_min;
        logic [TICK_W-1:0]  one_max;
        logic [INDEX_W-1:0] first_bit_index;
    } cfg_t;

    typedef struct packed {
        logic             frame_valid;
        logic [CMD_W-1:0] command;
    } result_t;

endpackage

`default_nettype wire

// ----- design/ipdd_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ipdd_edge_if;
    logic valid;
    logic ready;
    logic edge_req;

    modport source (output valid, output edge_req, input ready);
    modport sink (input valid, input edge_req, output ready);
endinterface

interface ipdd_result_if;
    logic       valid;
    logic       ready;
    logic       frame_valid;
    logic [7:0] command;

    modport source (output valid, output frame_valid, output command, input ready);
    modport sink (input valid, input frame_valid, input command, output ready);
endinterface

`default_nettype wire

// ----- design/ipdd_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipdd_cfg
    import ipdd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [REG_W-1:0]  cfg_index,
    input  wire logic [TICK_W-1:0] cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks   <= 20'd500000;
            cfg_reg.leader_min      <= 20'd10000;
            cfg_reg.leader_max      <= 20'd14000;
            cfg_reg.one_min         <= 20'd2000;
            cfg_reg.one_max         <= 20'd2300;
            cfg_reg.first_bit_index <= 6'd17;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT:    cfg_reg.timeout_ticks   <= cfg_wdata;
                REG_LEADER_MIN: cfg_reg.leader_min      <= cfg_wdata;
                REG_LEADER_MAX: cfg_reg.leader_max      <= cfg_wdata;
                REG_ONE_MIN:    cfg_reg.one_min         <= cfg_wdata;
                REG_ONE_MAX:    cfg_reg.one_max         <= cfg_wdata;
                REG_FIRST_BIT:  cfg_reg.first_bit_index <= cfg_wdata[INDEX_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/ipdd_frame.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ipdd_frame
    import ipdd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic step,
    input  wire logic edge_req,
    input  cfg_t      cfg,
    output logic      res_fire,
    output result_t   res
);

    logic               active_reg, active_next;
    logic [TICK_W-1:0]  elapsed_reg, elapsed_next;
    logic [INDEX_W-1:0] index_reg, index_next;
    logic               leader_reg, leader_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;

    logic [TICK_W-1:0]  e;
    logic [INDEX_W-1:0] bit_ofs;
    logic               in_cmd;
    logic               is_one;

    assign e       = (elapsed_reg == TICK_MAX) ? TICK_MAX : elapsed_reg + 1'b1;
    assign bit_ofs = index_reg - cfg.first_bit_index;
    assign in_cmd  = (index_reg >= cfg.first_bit_index) && (bit_ofs < INDEX_W'(CMD_W));
    assign is_one  = (e >= cfg.one_min) && (e <= cfg.one_max);

    always_comb
    begin
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        index_next   = index_reg;
        leader_next  = leader_reg;
        cmd_next     = cmd_reg;
        res_fire     = 1'b0;
        res.frame_valid = leader_reg;
        res.command     = leader_reg ? cmd_reg : '0;
        if (step)
        begin
            if (!active_reg)
            begin
                if (edge_req)
                begin
                    active_next  = 1'b1;
                    elapsed_next = '0;
                    index_next   = '0;
                    leader_next  = 1'b0;
                    cmd_next     = '0;
                end
            end
            else if (edge_req)
            begin
                if (index_reg != INDEX_MAX)
                begin
                    if (index_reg == '0)
                        leader_next = (e >= cfg.leader_min) && (e <= cfg.leader_max);
                    if (in_cmd)
                        cmd_next[bit_ofs[2:0]] = is_one;
                    index_next = index_reg + 1'b1;
                end
                elapsed_next = '0;
            end
            else
            begin
                elapsed_next = e;
                if (e >= cfg.timeout_ticks)
                begin
                    res_fire    = 1'b1;
                    active_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            elapsed_reg <= '0;
            index_reg   <= '0;
            leader_reg  <= 1'b0;
            cmd_reg     <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            elapsed_reg <= elapsed_next;
            index_reg   <= index_next;
            leader_reg  <= leader_next;
            cmd_reg     <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/ir_pulse_distance_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none

// pulse-distance IR decoder: one input word per timebase tick, edge_req set on a
// falling edge of the receiver line. a word is taken every cycle while the output
// is free or being drained; each passes an input register, where the interval
// measurement and window compares act on it, and the result of the tick that ends
// a frame lands in the output register once the output is free or being drained. a
// frame ends timeout_ticks after its last edge and yields frame_valid and the
// command byte (zero if the leader was out of its window). write configuration
// only while no frame is open.

module ir_pulse_distance_decoder
    import ipdd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    ipdd_edge_if.sink              edge_in,
    ipdd_result_if.source          result_out,
    input  wire logic              cfg_we,
    input  wire logic [REG_W-1:0]  cfg_index,
    input  wire logic [TICK_W-1:0] cfg_wdata
);

    cfg_t    cfg;
    logic    in_valid_reg;
    logic    edge_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    advance;
    logic    res_fire;
    result_t res;

    ipdd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipdd_frame u_frame (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .edge_req (edge_reg),
        .cfg      (cfg),
        .res_fire (res_fire),
        .res      (res)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign edge_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (edge_in.ready)
            in_valid_reg <= edge_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (edge_in.ready && edge_in.valid)
            edge_reg <= edge_in.edge_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && res_fire)
            out_valid_reg <= 1'b1;
        else if (result_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_fire)
            out_reg <= res;
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.frame_valid = out_reg.frame_valid;
    assign result_out.command     = out_reg.command;

endmodule

`default_nettype wire

// ----- dv/tb_ir_pulse_distance_decoder.sv -----
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder
    import ipdd_pkg::*;
();

    class ir_frame_tracker;
        cfg_t               regs;
        bit                 active;
        logic [TICK_W-1:0]  elapsed;
        logic [INDEX_W-1:0] next_idx;
        bit                 lead_ok;
        logic [CMD_W-1:0]   cmd_bits;
        result_t            pending_frames[$];
        int                 mismatch_cnt;
        int                 frames_seen;

        function new();
            regs.timeout_ticks   = 20'd500000;
            regs.leader_min      = 20'd10000;
            regs.leader_max      = 20'd14000;
            regs.one_min         = 20'd2000;
            regs.one_max         = 20'd2300;
            regs.first_bit_index = 6'd17;
            active       = 1'b0;
            elapsed      = '0;
            next_idx     = '0;
            lead_ok      = 1'b0;
            cmd_bits     = '0;
            mismatch_cnt = 0;
            frames_seen  = 0;
        endfunction

        function void set_reg(logic [REG_W-1:0] idx, logic [TICK_W-1:0] val);
            case (idx)
                REG_TIMEOUT:    regs.timeout_ticks   = val;
                REG_LEADER_MIN: regs.leader_min      = val;
                REG_LEADER_MAX: regs.leader_max      = val;
                REG_ONE_MIN:    regs.one_min         = val;
                REG_ONE_MAX:    regs.one_max         = val;
                REG_FIRST_BIT:  regs.first_bit_index = val[INDEX_W-1:0];
                default:        ;
            endcase
        endfunction

        function bit in_range(logic [TICK_W-1:0] v, logic [TICK_W-1:0] lo,
                              logic [TICK_W-1:0] hi);
            return v >= lo && v <= hi;
        endfunction

        // one accepted tick word
        function void take_tick(bit edge_bit);
            logic [TICK_W-1:0] e;
            int                pos;
            result_t           r;
            if (!active)
            begin
                if (edge_bit)
                begin
                    active   = 1'b1;
                    elapsed  = '0;
                    next_idx = '0;
                    lead_ok  = 1'b0;
                    cmd_bits = '0;
                end
                return;
            end
            e = (elapsed == TICK_MAX) ? TICK_MAX : elapsed + 1'b1;
            if (edge_bit)
            begin
                if (next_idx != INDEX_MAX)
                begin
                    if (next_idx == '0)
                        lead_ok = in_range(e, regs.leader_min, regs.leader_max);
                    pos = next_idx - regs.first_bit_index;
                    if (pos >= 0 && pos < CMD_W)
                        cmd_bits[pos] = in_range(e, regs.one_min, regs.one_max);
                    next_idx = next_idx + 1'b1;
                end
                elapsed = '0;
                return;
            end
            elapsed = e;
            if (e >= regs.timeout_ticks)
            begin
                r.frame_valid = lead_ok;
                r.command     = lead_ok ? cmd_bits : '0;
                pending_frames.push_back(r);
                active = 1'b0;
            end
        endfunction

        function void match_frame(logic fv, logic [CMD_W-1:0] cmd);
            result_t want;
            frames_seen++;
            if (pending_frames.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected frame: frame_valid=%0b command=%02h", fv, cmd);
                return;
            end
            want = pending_frames.pop_front();
            if (fv !== want.frame_valid || cmd !== want.command)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("frame mismatch: expected frame_valid=%0b command=%02h, %s%0b %s%02h",
                             want.frame_valid, want.command,
                             "got frame_valid=", fv, "command=", cmd);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic              cfg_we;
    logic [REG_W-1:0]  cfg_index;
    logic [TICK_W-1:0] cfg_wdata;

    ipdd_edge_if   edge_ch();
    ipdd_result_if result_ch();

    ir_frame_tracker tracker;
    int src_idle_pct;
    int sink_stall_pct;
    int busy_items;

    ir_pulse_distance_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_ch),
        .result_out (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= sink_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.match_frame(result_ch.frame_valid, result_ch.command);
    end

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1:       begin src_idle_pct = 58; sink_stall_pct = 0;  end
            2:       begin src_idle_pct = 0;  sink_stall_pct = 58; end
            default: begin src_idle_pct = 27; sink_stall_pct = 27; end
        endcase
    endtask

    // one tick word, held until taken
    task automatic send_tick(input bit edge_bit);
        while ($urandom_range(99) < src_idle_pct)
        begin
            edge_ch.valid    <= 1'b0;
            edge_ch.edge_req <= 1'($urandom_range(1));
            @(negedge clk);
        end
        edge_ch.valid    <= 1'b1;
        edge_ch.edge_req <= edge_bit;
        do
        begin
            @(posedge clk);
        end
        while (!edge_ch.ready);
        if (tracker.active || edge_bit)
            busy_items++;
        tracker.take_tick(edge_bit);
        @(negedge clk);
    endtask

    task automatic send_interval(input int len);
        repeat (len - 1) send_tick(1'b0);
        send_tick(1'b1);
    endtask

    task automatic close_frame();
        while (tracker.active)
            send_tick(1'b0);
    endtask

    // start edge, one edge per listed interval, then silence until timeout
    task automatic send_train(input int lens[$]);
        send_tick(1'b1);
        foreach (lens[i])
            send_interval(lens[i]);
        close_frame();
    endtask

    task automatic drain_results();
        edge_ch.valid <= 1'b0;
        while (tracker.pending_frames.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [REG_W-1:0] idx, input logic [TICK_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        tracker.set_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(REG_TIMEOUT, c.timeout_ticks);
        write_reg(REG_LEADER_MIN, c.leader_min);
        write_reg(REG_LEADER_MAX, c.leader_max);
        write_reg(REG_ONE_MIN, c.one_min);
        write_reg(REG_ONE_MAX, c.one_max);
        write_reg(REG_FIRST_BIT, TICK_W'(c.first_bit_index));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function automatic cfg_t make_cfg(int unsigned t, int unsigned lmin, int unsigned lmax,
                                      int unsigned omin, int unsigned omax, int unsigned fbi);
        cfg_t c;
        c.timeout_ticks   = TICK_W'(t);
        c.leader_min      = TICK_W'(lmin);
        c.leader_max      = TICK_W'(lmax);
        c.one_min         = TICK_W'(omin);
        c.one_max         = TICK_W'(omax);
        c.first_bit_index = INDEX_W'(fbi);
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        int unsigned lmin, lmax, omin, omax, t, fbi;
        lmin = $urandom_range(12, 4);
        lmax = lmin + $urandom_range(6, 0);
        omin = $urandom_range(4, 1);
        omax = omin + $urandom_range(3, 0);
        t = ((lmax + 1 > omax + 4) ? lmax + 1 : omax + 4) + $urandom_range(12, 0);
        case ($urandom_range(7))
            0:       fbi = 55;
            1, 2:    fbi = $urandom_range(55, 1);
            default: fbi = $urandom_range(8, 1);
        endcase
        return make_cfg(t, lmin, lmax, omin, omax, fbi);
    endfunction

    function automatic int one_len();
        return $urandom_range(tracker.regs.one_max, tracker.regs.one_min);
    endfunction

    function automatic int zero_len();
        if (tracker.regs.one_min > 1 && $urandom_range(1))
            return $urandom_range(tracker.regs.one_min - 1, 1);
        return tracker.regs.one_max + $urandom_range(3, 1);
    endfunction

    // mostly clean frames, some with a bad leader or a wrong bit count, some noise
    task automatic send_random_frame();
        int lens[$];
        int kind;
        int n_bits;
        kind = $urandom_range(99);
        if (kind < 10)
        begin
            send_tick(1'b1);
            repeat ($urandom_range(60, 1)) send_tick(1'($urandom_range(2) == 0));
            close_frame();
            repeat ($urandom_range(3)) send_tick(1'b0);
        end
        else
        begin
            if (kind < 20)
                lens.push_back($urandom_range(1) ? tracker.regs.leader_min - 1
                                                 : tracker.regs.leader_max + 1);
            else
                lens.push_back($urandom_range(tracker.regs.leader_max,
                                              tracker.regs.leader_min));
            for (int i = 1; i < tracker.regs.first_bit_index; i++)
                lens.push_back($urandom_range(tracker.regs.one_max + 3, 1));
            n_bits = (kind < 30) ? $urandom_range(12, 0) : 8;
            for (int i = 0; i < n_bits; i++)
                lens.push_back($urandom_range(1) ? one_len() : zero_len());
            send_train(lens);
        end
    endtask

    initial
    begin
        int lens[$];
        int phase;
        int start_items;

        tracker          = new();
        rst_n            = 1'b0;
        edge_ch.valid    = 1'b0;
        edge_ch.edge_req = 1'b0;
        result_ch.ready  = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        set_idling(0);
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // widest windows, shortest timeout: only back-to-back edges stay in the frame
        apply_settings(make_cfg(1, 0, TICK_MAX, 0, TICK_MAX, 1));
        send_tick(1'b0);
        send_tick(1'b0);
        lens.delete();
        send_train(lens);
        repeat (9) lens.push_back(1);
        send_train(lens);
        repeat (61) lens.push_back(1);
        send_train(lens);
        drain_results();

        // empty windows
        apply_settings(make_cfg(1, TICK_MAX, 0, TICK_MAX, 0, 55));
        send_train(lens);
        drain_results();

        // window edges, edge on the timeout tick, short frame after a full one
        apply_settings(make_cfg(20, 8, 10, 3, 5, 1));
        lens = {8, 3, 2, 5, 6, 3, 5, 6, 2};
        send_train(lens);
        lens = {10, 4, 4, 4, 4, 4, 4, 4, 4};
        send_train(lens);
        lens = {9, 5, 5, 5};
        send_train(lens);
        lens = {7, 3, 3, 3, 3, 3, 3, 3, 3};
        send_train(lens);
        lens = {11, 3, 3, 3, 3, 3, 3, 3, 3};
        send_train(lens);
        lens = {20, 20, 3, 3, 20, 3, 3, 3, 3};
        send_train(lens);
        drain_results();

        // more edges than the index can count
        apply_settings(make_cfg(20, 8, 10, 3, 5, 55));
        lens = {9};
        repeat (54) lens.push_back(4);
        lens = {lens, 3, 6, 5, 2, 4, 7, 3, 5, 3, 3, 3, 3, 3, 3, 3, 3};
        send_train(lens);
        drain_results();

        busy_items = 0;
        phase      = 0;
        while (phase < 4)
        begin
            set_idling(phase % 4);
            apply_settings(random_cfg());
            start_items = busy_items;
            while (busy_items - start_items < 200)
                send_random_frame();
            drain_results();
            phase++;
        end

        repeat (10) @(negedge clk);
        if (tracker.mismatch_cnt == 0 && tracker.pending_frames.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
